// ----- src/mhw_pkg.sv -----
// Shared types and constants of the multi-channel heartbeat watchdog.
// No dependencies; every other file of the block refers to this package.
package mhw_pkg;

    localparam int TIME_W  = 48;
    localparam int COUNT_W = 32;
    localparam int KIND_W  = 3;
    localparam int PID_W   = 16;
    localparam int TMO_W   = 32;
    localparam int IVL_W   = 16;
    localparam int REG_W   = 2;
    localparam int DATA_W  = 32;
    localparam int BITES_W = 2;

    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_KICK_KERNEL,
        CMD_KICK_SCHED,
        CMD_KICK_SYSCALL,
        CMD_KICK_IDLE,
        CMD_REPORT,
        CMD_STALL_START,
        CMD_STALL_END
    } t_cmd;

    localparam logic [REG_W-1:0] REG_ENABLE   = 2'd0;
    localparam logic [REG_W-1:0] REG_TIMEOUT  = 2'd1;
    localparam logic [REG_W-1:0] REG_INTERVAL = 2'd2;

    localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SCHED = 3'd1;
    localparam logic [KIND_W-1:0] KIND_IDLE  = 3'd2;

    localparam logic [PID_W-1:0] PID_NONE = 16'hFFFF;
    localparam logic [PID_W-1:0] PID_IDLE = 16'h0000;

    localparam logic [TMO_W-1:0] DEFAULT_TIMEOUT  = 32'd5000;
    localparam logic [IVL_W-1:0] DEFAULT_INTERVAL = 16'd1000;

    typedef struct packed {
        logic             enable;
        logic [TMO_W-1:0] tmo_limit;
        logic [IVL_W-1:0] check_interval_ms;
    } t_cfg;

    typedef struct packed {
        t_cmd                     cmd;
        logic [KIND_W-1:0]        event_kind;
        logic signed [PID_W-1:0]  event_pid;
    } t_item;

    typedef struct packed {
        logic [BITES_W-1:0]       bites;
        logic [COUNT_W-1:0]       evt_total;
        logic [TIME_W-1:0]        evt_time;
        logic [KIND_W-1:0]        evt_kind;
        logic signed [PID_W-1:0]  evt_pid;
        logic [COUNT_W-1:0]       kernel_beats;
        logic [COUNT_W-1:0]       sched_beats;
        logic [COUNT_W-1:0]       syscall_beats;
        logic [COUNT_W-1:0]       idle_beats;
        logic [TIME_W-1:0]        kernel_kick_age;
        logic [TIME_W-1:0]        sched_kick_age;
    } t_result;

endpackage

// ----- src/mhw_intf.sv -----
// Channel interfaces of the watchdog: command input, result output, config writes.
// Depends on mhw_pkg for field widths.
interface mhw_in_if;
    logic                               valid;
    logic                               ready;
    logic [2:0]                         cmd;
    logic [mhw_pkg::KIND_W-1:0]         event_kind;
    logic signed [mhw_pkg::PID_W-1:0]   event_pid;

    modport source (output valid, cmd, event_kind, event_pid, input ready);
    modport sink   (input valid, cmd, event_kind, event_pid, output ready);
endinterface

interface mhw_out_if;
    logic                               valid;
    logic                               ready;
    logic [mhw_pkg::BITES_W-1:0]        bites;
    logic [mhw_pkg::COUNT_W-1:0]        evt_total;
    logic [mhw_pkg::TIME_W-1:0]         evt_time;
    logic [mhw_pkg::KIND_W-1:0]         evt_kind;
    logic signed [mhw_pkg::PID_W-1:0]   evt_pid;
    logic [mhw_pkg::COUNT_W-1:0]        kernel_beats;
    logic [mhw_pkg::COUNT_W-1:0]        sched_beats;
    logic [mhw_pkg::COUNT_W-1:0]        syscall_beats;
    logic [mhw_pkg::COUNT_W-1:0]        idle_beats;
    logic [mhw_pkg::TIME_W-1:0]         kernel_kick_age;
    logic [mhw_pkg::TIME_W-1:0]         sched_kick_age;

    modport source (output valid, bites, evt_total, evt_time, evt_kind,
                    evt_pid, kernel_beats, sched_beats, syscall_beats,
                    idle_beats, kernel_kick_age, sched_kick_age, input ready);
    modport sink   (input valid, bites, evt_total, evt_time, evt_kind,
                    evt_pid, kernel_beats, sched_beats, syscall_beats,
                    idle_beats, kernel_kick_age, sched_kick_age, output ready);
endinterface

interface mhw_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mhw_pkg::REG_W-1:0]          index;
    logic [mhw_pkg::DATA_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/mhw_cfg_regs.sv -----
// Configuration register file of the watchdog: enable, timeout, check interval.
// Depends on mhw_pkg and the mhw_cfg_if interface.
module mhw_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mhw_cfg_if.sink         i_cfg,
    output mhw_pkg::t_cfg   o_cfg
);

    mhw_pkg::t_cfg r_cfg;
    mhw_pkg::t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                mhw_pkg::REG_ENABLE: begin
                    n_cfg.enable = i_cfg.data[0];
                end
                mhw_pkg::REG_TIMEOUT: begin
                    // zero would bite forever; fall back to the default
                    n_cfg.tmo_limit = (i_cfg.data == '0) ? mhw_pkg::DEFAULT_TIMEOUT
                                                        : i_cfg.data;
                end
                mhw_pkg::REG_INTERVAL: begin
                    n_cfg.check_interval_ms = i_cfg.data[mhw_pkg::IVL_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable            <= 1'b0;
            r_cfg.tmo_limit         <= mhw_pkg::DEFAULT_TIMEOUT;
            r_cfg.check_interval_ms <= mhw_pkg::DEFAULT_INTERVAL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- src/mhw_in_stage.sv -----
// Input register of the watchdog: captures one command transaction per cycle while the core keeps taking the held item.
// Depends on mhw_pkg and the mhw_in_if interface.
module mhw_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mhw_in_if.sink          i_in,
    input  logic            i_take,
    output logic            o_valid,
    output mhw_pkg::t_item  o_item
);

    logic           r_valid;
    mhw_pkg::t_item r_item;
    logic           w_load;

    // refill in the same cycle the held item moves on
    assign i_in.ready = !r_valid || i_take;
    assign w_load     = i_in.valid && i_in.ready;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.cmd        <= mhw_pkg::t_cmd'(i_in.cmd);
            r_item.event_kind <= i_in.event_kind;
            r_item.event_pid  <= i_in.event_pid;
        end
    end

endmodule

// ----- src/mhw_core.sv -----
// Watchdog state, per-command update and result register.
// Depends on mhw_pkg and the mhw_out_if interface.
module mhw_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  mhw_pkg::t_item  i_item,
    input  mhw_pkg::t_cfg   i_cfg,
    output logic            o_take,
    mhw_out_if.source       o_out
);

    localparam int TW = mhw_pkg::TIME_W;
    localparam int CW = mhw_pkg::COUNT_W;

    logic [TW-1:0]                  r_clock, r_clock_p1, n_clock, n_clock_p1;
    logic [CW-1:0]                  r_kernel_cnt, n_kernel_cnt;
    logic [CW-1:0]                  r_sched_cnt, n_sched_cnt;
    logic [CW-1:0]                  r_syscall_cnt, n_syscall_cnt;
    logic [CW-1:0]                  r_idle_cnt, n_idle_cnt;
    logic [TW-1:0]                  r_kernel_time, n_kernel_time;
    logic [TW-1:0]                  r_sched_time, n_sched_time;
    logic [TW-1:0]                  r_idle_time, n_idle_time;
    logic [TW-1:0]                  r_check_time, n_check_time;
    logic                           r_stall, n_stall;
    logic                           r_idle_bit, n_idle_bit;
    logic [CW-1:0]                  r_events, n_events;
    logic [TW-1:0]                  r_latest_time, n_latest_time;
    logic [mhw_pkg::KIND_W-1:0]     r_latest_kind, n_latest_kind;
    logic [mhw_pkg::PID_W-1:0]      r_latest_pid, n_latest_pid;
    logic                           r_out_valid;
    mhw_pkg::t_result               r_res, n_res;

    logic                           w_fire;
    logic [TW-1:0]                  w_since_chk, w_sched_age, w_idle_age;
    logic [TW-1:0]                  w_ivl, w_tmo;
    logic                           w_check, w_sched_hit, w_idle_hit, w_report;
    logic [mhw_pkg::BITES_W-1:0]    w_bites;

    assign w_fire = i_valid && (!r_out_valid || o_out.ready);
    assign o_take = w_fire;

    assign w_ivl       = {{(TW - mhw_pkg::IVL_W){1'b0}}, i_cfg.check_interval_ms};
    assign w_tmo       = {{(TW - mhw_pkg::TMO_W){1'b0}}, i_cfg.tmo_limit};
    // a tick checks against the advanced clock
    assign w_since_chk = r_clock_p1 - r_check_time;
    assign w_sched_age = r_clock_p1 - r_sched_time;
    assign w_idle_age  = r_clock_p1 - r_idle_time;

    assign w_check     = (i_item.cmd == mhw_pkg::CMD_TICK) && i_cfg.enable
                         && (w_since_chk >= w_ivl);
    assign w_sched_hit = w_check && (r_sched_cnt != '0) && (w_sched_age > w_tmo);
    assign w_idle_hit  = w_check && (r_idle_cnt != '0) && !r_idle_bit
                         && (w_idle_age > w_tmo);
    assign w_report    = (i_item.cmd == mhw_pkg::CMD_REPORT) && i_cfg.enable;
    assign w_bites     = w_report ? 2'd1
                                  : ({1'b0, w_sched_hit} + {1'b0, w_idle_hit});

    always_comb begin
        n_clock       = r_clock;
        n_clock_p1    = r_clock_p1;
        n_kernel_cnt  = r_kernel_cnt;
        n_sched_cnt   = r_sched_cnt;
        n_syscall_cnt = r_syscall_cnt;
        n_idle_cnt    = r_idle_cnt;
        n_kernel_time = r_kernel_time;
        n_sched_time  = r_sched_time;
        n_idle_time   = r_idle_time;
        n_check_time  = r_check_time;
        n_stall       = r_stall;
        n_idle_bit    = r_idle_bit;
        case (i_item.cmd)
            mhw_pkg::CMD_TICK: begin
                n_clock    = r_clock_p1;
                n_clock_p1 = r_clock_p1 + 1'b1;
                if (w_check) begin
                    n_check_time = r_clock_p1;
                end
                if (w_idle_hit) begin
                    n_idle_bit = 1'b1;
                end
            end
            mhw_pkg::CMD_KICK_KERNEL: begin
                n_kernel_cnt  = r_kernel_cnt + 1'b1;
                n_kernel_time = r_clock;
            end
            mhw_pkg::CMD_KICK_SCHED: begin
                // drop scheduler kicks while a stall is being simulated
                if (!r_stall) begin
                    n_sched_cnt  = r_sched_cnt + 1'b1;
                    n_sched_time = r_clock;
                end
            end
            mhw_pkg::CMD_KICK_SYSCALL: begin
                n_syscall_cnt = r_syscall_cnt + 1'b1;
            end
            mhw_pkg::CMD_KICK_IDLE: begin
                n_idle_cnt  = r_idle_cnt + 1'b1;
                n_idle_time = r_clock;
                n_idle_bit  = 1'b0;
            end
            mhw_pkg::CMD_STALL_START: begin
                if (i_cfg.enable) begin
                    n_sched_time = r_clock;
                    n_stall      = 1'b1;
                    // back-date so the next tick runs the checks if the clock has reached the interval
                    n_check_time = (r_clock > w_ivl) ? (r_clock - w_ivl) : '0;
                end
            end
            mhw_pkg::CMD_STALL_END: begin
                if (r_stall) begin
                    n_stall      = 1'b0;
                    n_sched_time = r_clock;
                    n_sched_cnt  = r_sched_cnt + 1'b1;
                end
            end
            default: begin
                n_clock = r_clock;
            end
        endcase
    end

    always_comb begin
        n_events      = r_events + {{(CW - mhw_pkg::BITES_W){1'b0}}, w_bites};
        n_latest_time = r_latest_time;
        n_latest_kind = r_latest_kind;
        n_latest_pid  = r_latest_pid;
        if (w_bites != '0) begin
            n_latest_time = n_clock;
        end
        // the idle event is logged after the scheduler event and wins
        if (w_idle_hit) begin
            n_latest_kind = mhw_pkg::KIND_IDLE;
            n_latest_pid  = mhw_pkg::PID_IDLE;
        end else if (w_sched_hit) begin
            n_latest_kind = mhw_pkg::KIND_SCHED;
            n_latest_pid  = mhw_pkg::PID_NONE;
        end else if (w_report) begin
            n_latest_kind = i_item.event_kind;
            n_latest_pid  = i_item.event_pid;
        end
    end

    always_comb begin
        n_res.bites           = w_bites;
        n_res.evt_total       = n_events;
        n_res.evt_time        = n_latest_time;
        n_res.evt_kind        = n_latest_kind;
        n_res.evt_pid         = n_latest_pid;
        n_res.kernel_beats    = n_kernel_cnt;
        n_res.sched_beats     = n_sched_cnt;
        n_res.syscall_beats   = n_syscall_cnt;
        n_res.idle_beats      = n_idle_cnt;
        n_res.kernel_kick_age = (n_clock > n_kernel_time) ? (n_clock - n_kernel_time) : '0;
        n_res.sched_kick_age  = (n_clock > n_sched_time) ? (n_clock - n_sched_time) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock       <= '0;
            r_clock_p1    <= {{(TW - 1){1'b0}}, 1'b1};
            r_kernel_cnt  <= '0;
            r_sched_cnt   <= '0;
            r_syscall_cnt <= '0;
            r_idle_cnt    <= '0;
            r_kernel_time <= '0;
            r_sched_time  <= '0;
            r_idle_time   <= '0;
            r_check_time  <= '0;
            r_stall       <= 1'b0;
            r_idle_bit    <= 1'b0;
            r_events      <= '0;
            r_latest_time <= '0;
            r_latest_kind <= mhw_pkg::KIND_NONE;
            r_latest_pid  <= mhw_pkg::PID_NONE;
        end else if (w_fire) begin
            r_clock       <= n_clock;
            r_clock_p1    <= n_clock_p1;
            r_kernel_cnt  <= n_kernel_cnt;
            r_sched_cnt   <= n_sched_cnt;
            r_syscall_cnt <= n_syscall_cnt;
            r_idle_cnt    <= n_idle_cnt;
            r_kernel_time <= n_kernel_time;
            r_sched_time  <= n_sched_time;
            r_idle_time   <= n_idle_time;
            r_check_time  <= n_check_time;
            r_stall       <= n_stall;
            r_idle_bit    <= n_idle_bit;
            r_events      <= n_events;
            r_latest_time <= n_latest_time;
            r_latest_kind <= n_latest_kind;
            r_latest_pid  <= n_latest_pid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.bites           = r_res.bites;
    assign o_out.evt_total       = r_res.evt_total;
    assign o_out.evt_time        = r_res.evt_time;
    assign o_out.evt_kind        = r_res.evt_kind;
    assign o_out.evt_pid         = r_res.evt_pid;
    assign o_out.kernel_beats    = r_res.kernel_beats;
    assign o_out.sched_beats     = r_res.sched_beats;
    assign o_out.syscall_beats   = r_res.syscall_beats;
    assign o_out.idle_beats      = r_res.idle_beats;
    assign o_out.kernel_kick_age = r_res.kernel_kick_age;
    assign o_out.sched_kick_age  = r_res.sched_kick_age;

    a_clock_p1_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clock_p1 == r_clock + 1'b1)
        else $error("incremented clock copy out of step");

    a_events_add_bites: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_events == $past(r_events) + {{(CW - mhw_pkg::BITES_W){1'b0}},
                                                  $past(w_bites)})
        else $error("event total does not follow bites");

    a_disabled_no_bite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && !i_cfg.enable |=> r_res.bites == '0)
        else $error("event recorded while disabled");

    a_stall_blocks_kick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_stall && (i_item.cmd == mhw_pkg::CMD_KICK_SCHED)
        |=> $stable(r_sched_cnt) && $stable(r_sched_time))
        else $error("scheduler kick taken during stall");

endmodule

// ----- src/multi_heartbeat_watchdog.sv -----
// Multi-channel heartbeat watchdog, top level: config registers, input
// register and watchdog core. The block accepts one command per clock as long
// as the result channel takes a result every cycle; each command gives exactly
// one result, registered in the result register of the core after the input
// register. Config writes are taken every cycle and must only happen
// while idle.
// Depends on mhw_pkg, the interfaces in mhw_intf, mhw_cfg_regs, mhw_in_stage
// and mhw_core.
module multi_heartbeat_watchdog (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mhw_in_if.sink      i_in,
    mhw_out_if.source   o_out,
    mhw_cfg_if.sink     i_cfg
);

    mhw_pkg::t_cfg  w_cfg;
    mhw_pkg::t_item w_item;
    logic           w_item_valid;
    logic           w_take;

    mhw_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    mhw_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    mhw_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_item_valid),
        .i_item  (w_item),
        .i_cfg   (w_cfg),
        .o_take  (w_take),
        .o_out   (o_out)
    );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of multi_heartbeat_watchdog: directed and random commands,
// register writes between phases, random idling on both channels, per-field result checks.
// Depends on mhw_pkg, the channel interfaces in mhw_intf.sv and the watchdog RTL.
module testbench;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 5;
    localparam int PHASE_ITEMS   = 110;
    localparam int NUM_PHASES    = 6;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 40;
    localparam int CMP_W         = mhw_pkg::TIME_W;
    localparam logic [mhw_pkg::REG_W-1:0]  REG_SPARE        = 2'd3;
    localparam logic [mhw_pkg::KIND_W-1:0] KIND_KERNEL_HANG = 3'd3;
    localparam logic [mhw_pkg::KIND_W-1:0] KIND_MANUAL      = 3'd5;
    localparam logic [mhw_pkg::KIND_W-1:0] KIND_RSVD_A      = 3'd6;
    localparam logic [mhw_pkg::KIND_W-1:0] KIND_RSVD_B      = 3'd7;

    logic clk;
    logic rst_n;

    mhw_in_if  in_ch ();
    mhw_out_if out_ch ();
    mhw_cfg_if cfg_ch ();

    multi_heartbeat_watchdog u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Shadow copy of the watchdog registers and state
    logic                          wd_enable      = 1'b0;
    logic [mhw_pkg::TMO_W-1:0]     wd_timeout     = mhw_pkg::DEFAULT_TIMEOUT;
    logic [mhw_pkg::IVL_W-1:0]     wd_interval    = mhw_pkg::DEFAULT_INTERVAL;
    logic [mhw_pkg::TIME_W-1:0]    now_ms         = '0;
    logic [mhw_pkg::TIME_W-1:0]    kernel_kick_ms = '0;
    logic [mhw_pkg::TIME_W-1:0]    sched_kick_ms  = '0;
    logic [mhw_pkg::TIME_W-1:0]    idle_kick_ms   = '0;
    logic [mhw_pkg::TIME_W-1:0]    checked_ms     = '0;
    logic [mhw_pkg::TIME_W-1:0]    event_ms       = '0;
    logic [mhw_pkg::COUNT_W-1:0]   kernel_cnt     = '0;
    logic [mhw_pkg::COUNT_W-1:0]   sched_cnt      = '0;
    logic [mhw_pkg::COUNT_W-1:0]   syscall_cnt    = '0;
    logic [mhw_pkg::COUNT_W-1:0]   idle_cnt       = '0;
    logic [mhw_pkg::COUNT_W-1:0]   event_cnt      = '0;
    logic [mhw_pkg::KIND_W-1:0]    event_kind_q   = mhw_pkg::KIND_NONE;
    logic [mhw_pkg::PID_W-1:0]     event_pid_q    = mhw_pkg::PID_NONE;
    logic                          stalled        = 1'b0;
    logic                          idle_bitten    = 1'b0;

    mhw_pkg::t_item   pending_cmds[$];
    mhw_pkg::t_result status_due[$];
    mhw_pkg::t_item   sent_item;
    mhw_pkg::t_item   next_item;
    mhw_pkg::t_result sent_status;
    mhw_pkg::t_result want;

    int err_cnt        = 0;
    int cmds_queued    = 0;
    int cmds_taken     = 0;
    int results_seen   = 0;
    int bites_total    = 0;
    int double_bites   = 0;
    int reg_writes     = 0;
    int quiet_cycles   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left;
    logic hold_req = 1'b0;
    logic hold_done;

    function automatic logic [mhw_pkg::TIME_W-1:0] age_since(
        input logic [mhw_pkg::TIME_W-1:0] kick_ms);
        return (now_ms > kick_ms) ? now_ms - kick_ms : '0;
    endfunction

    function automatic void log_event(input logic [mhw_pkg::KIND_W-1:0] kind,
                                      input logic [mhw_pkg::PID_W-1:0] pid);
        event_cnt    = event_cnt + 1'b1;
        event_ms     = now_ms;
        event_kind_q = kind;
        event_pid_q  = pid;
    endfunction

    // Apply one command to the shadow state and return the status it produces
    function automatic mhw_pkg::t_result advance_watchdog(input mhw_pkg::t_item it);
        mhw_pkg::t_result                r;
        logic [mhw_pkg::BITES_W-1:0]     bites;
        logic [mhw_pkg::TIME_W-1:0]      span;
        bites = '0;
        case (it.cmd)
            mhw_pkg::CMD_TICK: begin
                now_ms = now_ms + 1'b1;
                span   = now_ms - checked_ms;
                if (wd_enable && span >= wd_interval) begin
                    checked_ms = now_ms;
                    span = now_ms - sched_kick_ms;
                    if (sched_cnt != '0 && span > wd_timeout) begin
                        log_event(mhw_pkg::KIND_SCHED, mhw_pkg::PID_NONE);
                        bites = bites + 1'b1;
                    end
                    span = now_ms - idle_kick_ms;
                    // idle stall bites once until the next idle kick
                    if (idle_cnt != '0 && !idle_bitten && span > wd_timeout) begin
                        idle_bitten = 1'b1;
                        log_event(mhw_pkg::KIND_IDLE, mhw_pkg::PID_IDLE);
                        bites = bites + 1'b1;
                    end
                end
            end
            mhw_pkg::CMD_KICK_KERNEL: begin
                kernel_cnt     = kernel_cnt + 1'b1;
                kernel_kick_ms = now_ms;
            end
            mhw_pkg::CMD_KICK_SCHED: begin
                if (!stalled) begin
                    sched_cnt     = sched_cnt + 1'b1;
                    sched_kick_ms = now_ms;
                end
            end
            mhw_pkg::CMD_KICK_SYSCALL: begin
                syscall_cnt = syscall_cnt + 1'b1;
            end
            mhw_pkg::CMD_KICK_IDLE: begin
                idle_cnt     = idle_cnt + 1'b1;
                idle_kick_ms = now_ms;
                idle_bitten  = 1'b0;
            end
            mhw_pkg::CMD_REPORT: begin
                if (wd_enable) begin
                    log_event(it.event_kind, it.event_pid);
                    bites = bites + 1'b1;
                end
            end
            mhw_pkg::CMD_STALL_START: begin
                if (wd_enable) begin
                    sched_kick_ms = now_ms;
                    stalled       = 1'b1;
                    // back-date the last check so the next tick runs one if the clock has reached the interval
                    checked_ms = (now_ms > wd_interval) ? now_ms - wd_interval : '0;
                end
            end
            mhw_pkg::CMD_STALL_END: begin
                if (stalled) begin
                    stalled       = 1'b0;
                    sched_kick_ms = now_ms;
                    sched_cnt     = sched_cnt + 1'b1;
                end
            end
        endcase
        r.bites           = bites;
        r.evt_total       = event_cnt;
        r.evt_time        = event_ms;
        r.evt_kind        = event_kind_q;
        r.evt_pid         = event_pid_q;
        r.kernel_beats    = kernel_cnt;
        r.sched_beats     = sched_cnt;
        r.syscall_beats   = syscall_cnt;
        r.idle_beats      = idle_cnt;
        r.kernel_kick_age = age_since(kernel_kick_ms);
        r.sched_kick_age  = age_since(sched_kick_ms);
        return r;
    endfunction

    task automatic queue_cmd(input mhw_pkg::t_cmd cmd,
                             input logic [mhw_pkg::KIND_W-1:0] kind,
                             input logic signed [mhw_pkg::PID_W-1:0] pid);
        mhw_pkg::t_item it;
        it.cmd        = cmd;
        it.event_kind = kind;
        it.event_pid  = pid;
        pending_cmds.push_back(it);
        cmds_queued++;
    endtask

    // Call right after a rising edge; returns right after one
    task automatic write_reg(input logic [mhw_pkg::REG_W-1:0] idx,
                             input logic [mhw_pkg::DATA_W-1:0] value);
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        cfg_ch.valid <= 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            mhw_pkg::REG_ENABLE:   wd_enable   = value[0];
            mhw_pkg::REG_TIMEOUT:  wd_timeout  = (value == '0) ? mhw_pkg::DEFAULT_TIMEOUT
                                                               : value;
            mhw_pkg::REG_INTERVAL: wd_interval = value[mhw_pkg::IVL_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        while (results_seen != cmds_queued)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic compare_field(input string name, input logic [CMP_W-1:0] exp_v,
                                 input logic [CMP_W-1:0] got_v);
        if (got_v !== exp_v) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // Command driver: present the next pending item once the current one is taken
    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                sent_item.cmd        = mhw_pkg::t_cmd'(in_ch.cmd);
                sent_item.event_kind = in_ch.event_kind;
                sent_item.event_pid  = in_ch.event_pid;
                sent_status = advance_watchdog(sent_item);
                status_due.push_back(sent_status);
                cmds_taken++;
                bites_total += int'(sent_status.bites);
                if (sent_status.bites == 2'd2)
                    double_bites++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_item = pending_cmds.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.cmd        <= next_item.cmd;
                    in_ch.event_kind <= next_item.event_kind;
                    in_ch.event_pid  <= next_item.event_pid;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result sink: random stalls plus one long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result monitor
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (status_due.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, got event total %0h",
                             $time, out_ch.evt_total);
            end else begin
                want = status_due.pop_front();
                compare_field("bites", CMP_W'(want.bites), CMP_W'(out_ch.bites));
                compare_field("event total", CMP_W'(want.evt_total),
                              CMP_W'(out_ch.evt_total));
                compare_field("event time", want.evt_time, out_ch.evt_time);
                compare_field("event kind", CMP_W'(want.evt_kind), CMP_W'(out_ch.evt_kind));
                compare_field("event pid", CMP_W'(want.evt_pid), CMP_W'(out_ch.evt_pid));
                compare_field("kernel_beats", CMP_W'(want.kernel_beats),
                              CMP_W'(out_ch.kernel_beats));
                compare_field("sched_beats", CMP_W'(want.sched_beats),
                              CMP_W'(out_ch.sched_beats));
                compare_field("syscall_beats", CMP_W'(want.syscall_beats),
                              CMP_W'(out_ch.syscall_beats));
                compare_field("idle_beats", CMP_W'(want.idle_beats),
                              CMP_W'(out_ch.idle_beats));
                compare_field("kernel_kick_age", want.kernel_kick_age, out_ch.kernel_kick_age);
                compare_field("sched_kick_age", want.sched_kick_age, out_ch.sched_kick_age);
            end
        end
    end

    // Abort when no transaction happens on any channel for too long
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int                             ph;
        int                             n;
        int                             pick;
        mhw_pkg::t_cmd                  cmd;
        logic [mhw_pkg::PID_W-1:0]      pid;
        logic [mhw_pkg::DATA_W-1:0]     en_v;
        logic [mhw_pkg::DATA_W-1:0]     tmo_v;
        logic [mhw_pkg::DATA_W-1:0]     ivl_v;

        rst_n        = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = mhw_pkg::REG_ENABLE;
        cfg_ch.data  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Disabled after reset: kicks count, report and stall commands are dropped
        queue_cmd(mhw_pkg::CMD_TICK, mhw_pkg::KIND_NONE, 16'sd0);
        queue_cmd(mhw_pkg::CMD_KICK_KERNEL, mhw_pkg::KIND_NONE, 16'sd0);
        queue_cmd(mhw_pkg::CMD_KICK_SCHED, mhw_pkg::KIND_NONE, 16'sd0);
        queue_cmd(mhw_pkg::CMD_KICK_SYSCALL, mhw_pkg::KIND_NONE, 16'sd0);
        queue_cmd(mhw_pkg::CMD_KICK_IDLE, mhw_pkg::KIND_NONE, 16'sd0);
        queue_cmd(mhw_pkg::CMD_REPORT, KIND_MANUAL, 16'sd100);
        queue_cmd(mhw_pkg::CMD_STALL_START, mhw_pkg::KIND_NONE, 16'sd0);
        queue_cmd(mhw_pkg::CMD_STALL_END, mhw_pkg::KIND_NONE, 16'sd0);
        queue_cmd(mhw_pkg::CMD_TICK, mhw_pkg::KIND_NONE, 16'sd0);
        wait_idle();

        // Enabled, shortest timeout, check on every tick
        write_reg(mhw_pkg::REG_ENABLE, 32'h1);
        write_reg(mhw_pkg::REG_TIMEOUT, 32'd1);
        write_reg(mhw_pkg::REG_INTERVAL, 32'd0);
        queue_cmd(mhw_pkg::CMD_KICK_IDLE, mhw_pkg::KIND_NONE, 16'sd0);
        queue_cmd(mhw_pkg::CMD_KICK_SCHED, mhw_pkg::KIND_NONE, 16'sd0);
        queue_cmd(mhw_pkg::CMD_TICK, mhw_pkg::KIND_NONE, 16'sd0);
        queue_cmd(mhw_pkg::CMD_TICK, mhw_pkg::KIND_NONE, 16'sd0);
        queue_cmd(mhw_pkg::CMD_TICK, mhw_pkg::KIND_NONE, 16'sd0);
        queue_cmd(mhw_pkg::CMD_REPORT, KIND_RSVD_B, 16'sh8000);
        queue_cmd(mhw_pkg::CMD_REPORT, mhw_pkg::KIND_NONE, 16'sd32767);
        queue_cmd(mhw_pkg::CMD_REPORT, KIND_RSVD_A, -16'sd1);
        queue_cmd(mhw_pkg::CMD_STALL_START, mhw_pkg::KIND_NONE, 16'sd0);
        queue_cmd(mhw_pkg::CMD_KICK_SCHED, mhw_pkg::KIND_NONE, 16'sd0);
        queue_cmd(mhw_pkg::CMD_TICK, mhw_pkg::KIND_NONE, 16'sd0);
        queue_cmd(mhw_pkg::CMD_TICK, mhw_pkg::KIND_NONE, 16'sd0);
        queue_cmd(mhw_pkg::CMD_STALL_END, mhw_pkg::KIND_NONE, 16'sd0);
        queue_cmd(mhw_pkg::CMD_STALL_END, mhw_pkg::KIND_NONE, 16'sd0);
        queue_cmd(mhw_pkg::CMD_REPORT, KIND_KERNEL_HANG, 16'sd0);
        wait_idle();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    en_v = 32'h1; tmo_v = 32'd1; ivl_v = 32'd0;
                    send_idle_pct = 0; recv_stall_pct = 0;
                end
                1: begin
                    en_v = 32'h3; tmo_v = 32'd5; ivl_v = 32'd3;
                    send_idle_pct = 62; recv_stall_pct = 0;
                end
                2: begin
                    en_v = 32'hFFFF_FFFF; tmo_v = 32'd2; ivl_v = 32'hFFFF_FFFF;
                    send_idle_pct = 0; recv_stall_pct = 62;
                end
                3: begin
                    en_v = 32'h1; tmo_v = 32'hFFFF_FFFF; ivl_v = 32'd2;
                    send_idle_pct = 35; recv_stall_pct = 35;
                end
                4: begin
                    en_v = 32'hFFFF_FFFE; tmo_v = 32'd0; ivl_v = 32'h0001_0007;
                    send_idle_pct = 35; recv_stall_pct = 35;
                end
                default: begin
                    en_v = 32'h1; tmo_v = 32'd3; ivl_v = 32'd1;
                    send_idle_pct = 0; recv_stall_pct = 35;
                end
            endcase
            write_reg(mhw_pkg::REG_ENABLE, en_v);
            write_reg(mhw_pkg::REG_TIMEOUT, tmo_v);
            write_reg(mhw_pkg::REG_INTERVAL, ivl_v);
            if (ph == 4)
                write_reg(REG_SPARE, 32'hA5A5_5A5A);
            // long sink hold-off while commands keep coming
            if (ph == NUM_PHASES - 1)
                hold_req = 1'b1;

            for (n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < 40)      cmd = mhw_pkg::CMD_TICK;
                else if (pick < 50) cmd = mhw_pkg::CMD_KICK_KERNEL;
                else if (pick < 60) cmd = mhw_pkg::CMD_KICK_SCHED;
                else if (pick < 65) cmd = mhw_pkg::CMD_KICK_SYSCALL;
                else if (pick < 75) cmd = mhw_pkg::CMD_KICK_IDLE;
                else if (pick < 85) cmd = mhw_pkg::CMD_REPORT;
                else if (pick < 92) cmd = mhw_pkg::CMD_STALL_START;
                else                cmd = mhw_pkg::CMD_STALL_END;
                case ($urandom_range(7))
                    0:       pid = mhw_pkg::PID_NONE;
                    1:       pid = mhw_pkg::PID_IDLE;
                    default: pid = mhw_pkg::PID_W'($urandom);
                endcase
                queue_cmd(cmd, mhw_pkg::KIND_W'($urandom_range(7)), pid);
            end
            wait_idle();
        end

        if (status_due.size() != 0) begin
            err_cnt++;
            $display("%0t: %0d results never arrived, expected none left, got %0d",
                     $time, status_due.size(), status_due.size());
        end
        $display("covered %0d commands and %0d checked results over %0d register writes",
                 cmds_taken, results_seen, reg_writes);
        $display("watchdog recorded %0d events, %0d ticks bit on both scheduler and idle",
                 bites_total, double_bites);
        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
